### src/stb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package stb_pkg;

    localparam int NUM_SLOTS = 16;
    localparam int SLOT_W    = 4;
    localparam int TICK_BITS = 32;
    localparam int TAG_BITS  = 32;

    typedef enum logic [2:0] {
        CMD_TICK   = 3'd0,
        CMD_CREATE = 3'd1,
        CMD_START  = 3'd2,
        CMD_STOP   = 3'd3,
        CMD_CHANGE = 3'd4,
        CMD_DELETE = 3'd5,
        CMD_TAG    = 3'd6
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_RESP   = 2'd0,
        KIND_EXPIRY = 2'd1,
        KIND_DONE   = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESPOND,
        ST_SCAN_CHECK,
        ST_SCAN_EVAL,
        ST_SCAN_EMIT,
        ST_TICK_DONE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load_in;
        logic inc_idx;
        logic scan_commit;
        logic cmd_commit;
        logic done_emit;
    } stb_ctrl_t;

    // Datapath to controller
    typedef struct packed {
        logic is_tick;
        logic slot_live;
        logic reached;
        logic idx_last;
        logic out_free;
    } stb_stat_t;

endpackage

`default_nettype wire

### src/stb_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module stb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### src/stb_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module stb_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire stb_pkg::stb_stat_t stat,
    output stb_pkg::stb_ctrl_t     ctrl
);

    stb_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= stb_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ctrl       = '0;
        s_ready    = 1'b0;
        case (state_reg)
            stb_pkg::ST_IDLE: begin
                s_ready      = 1'b1;
                ctrl.load_in = s_valid;
                if (s_valid) begin
                    state_next = stb_pkg::ST_EXEC;
                end
            end
            // slot read in flight; tick branches to the scan
            stb_pkg::ST_EXEC: begin
                state_next = stat.is_tick ? stb_pkg::ST_SCAN_CHECK : stb_pkg::ST_RESPOND;
            end
            stb_pkg::ST_RESPOND: begin
                if (stat.out_free) begin
                    ctrl.cmd_commit = 1'b1;
                    state_next      = stb_pkg::ST_IDLE;
                end
            end
            stb_pkg::ST_SCAN_CHECK: begin
                if (stat.slot_live) begin
                    state_next = stb_pkg::ST_SCAN_EVAL;
                end else if (stat.idx_last) begin
                    state_next = stb_pkg::ST_TICK_DONE;
                end else begin
                    ctrl.inc_idx = 1'b1;
                end
            end
            stb_pkg::ST_SCAN_EVAL: begin
                if (stat.reached) begin
                    state_next = stb_pkg::ST_SCAN_EMIT;
                end else if (stat.idx_last) begin
                    state_next = stb_pkg::ST_TICK_DONE;
                end else begin
                    ctrl.inc_idx = 1'b1;
                    state_next   = stb_pkg::ST_SCAN_CHECK;
                end
            end
            stb_pkg::ST_SCAN_EMIT: begin
                if (stat.out_free) begin
                    ctrl.scan_commit = 1'b1;
                    if (stat.idx_last) begin
                        state_next = stb_pkg::ST_TICK_DONE;
                    end else begin
                        ctrl.inc_idx = 1'b1;
                        state_next   = stb_pkg::ST_SCAN_CHECK;
                    end
                end
            end
            stb_pkg::ST_TICK_DONE: begin
                if (stat.out_free) begin
                    ctrl.done_emit = 1'b1;
                    state_next     = stb_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = stb_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### src/stb_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module stb_datapath (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire stb_pkg::stb_ctrl_t            ctrl,
    output stb_pkg::stb_stat_t                 stat,
    input  wire logic [2:0]                    s_command,
    input  wire logic [stb_pkg::SLOT_W-1:0]    s_slot,
    input  wire logic [stb_pkg::TICK_BITS-1:0] s_now,
    input  wire logic [stb_pkg::TICK_BITS-1:0] s_period,
    input  wire logic                          s_reload,
    input  wire logic [stb_pkg::TAG_BITS-1:0]  s_tag,
    input  wire logic                          s_handler_present,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [1:0]                         m_kind,
    output logic                               m_status,
    output logic [stb_pkg::SLOT_W-1:0]         m_result_slot,
    output logic [stb_pkg::TAG_BITS-1:0]       m_result_tag,
    output logic                               m_last
);

    localparam int SW = stb_pkg::SLOT_W;
    localparam int NS = stb_pkg::NUM_SLOTS;
    localparam int TB = stb_pkg::TICK_BITS;
    localparam int GB = stb_pkg::TAG_BITS;

    // captured command
    logic [2:0]    command_reg;
    logic [SW-1:0] slot_reg;
    logic [TB-1:0] now_reg;
    logic [TB-1:0] period_reg;
    logic          reload_reg;
    logic [GB-1:0] tag_reg;
    logic          handler_reg;

    logic [SW-1:0] idx_reg, idx_next;
    logic [NS-1:0] used_reg, used_next;
    logic [NS-1:0] active_reg, active_next;

    logic          m_valid_reg, m_valid_next;
    logic [1:0]    kind_reg, kind_next;
    logic          status_reg, status_next;
    logic [SW-1:0] rslot_reg, rslot_next;
    logic [GB-1:0] rtag_reg, rtag_next;
    logic          last_reg, last_next;

    logic          is_tick;
    logic [SW-1:0] raddr;
    logic [TB-1:0] rd_expiry;
    logic [TB-1:0] rd_period;
    logic [GB:0]   rd_tagrel;

    logic          exp_we, per_we, tag_we;
    logic [SW-1:0] exp_waddr, per_waddr;
    logic [TB-1:0] exp_wdata;
    logic [TB-1:0] add_b, sum;
    logic [TB-1:0] diff;
    logic [SW-1:0] free_idx;
    logic          any_free;
    logic          slot_ok;
    logic          pass;

    assign is_tick = (command_reg == stb_pkg::CMD_TICK);
    assign raddr   = is_tick ? idx_reg : slot_reg;
    assign slot_ok = used_reg[slot_reg];

    // lowest free slot
    always_comb begin
        free_idx = '0;
        for (int i = NS - 1; i >= 0; i--) begin
            if (!used_reg[i]) begin
                free_idx = SW'(i);
            end
        end
    end
    assign any_free = ~&used_reg;

    // change period uses the new period, start and reload use the stored one
    assign add_b = (command_reg == stb_pkg::CMD_CHANGE) ? period_reg : rd_period;
    assign sum   = now_reg + add_b;
    assign diff  = now_reg - rd_expiry;

    always_comb begin
        case (command_reg)
            stb_pkg::CMD_CREATE: pass = (period_reg != '0) && handler_reg && any_free;
            stb_pkg::CMD_START,
            stb_pkg::CMD_STOP,
            stb_pkg::CMD_DELETE,
            stb_pkg::CMD_TAG:    pass = slot_ok;
            stb_pkg::CMD_CHANGE: pass = slot_ok && (period_reg != '0);
            default:             pass = 1'b0;
        endcase
    end

    always_comb begin
        stat.is_tick   = is_tick;
        stat.slot_live = used_reg[idx_reg] && active_reg[idx_reg];
        stat.reached   = !diff[TB-1];
        stat.idx_last  = (idx_reg == SW'(NS - 1));
        stat.out_free  = !m_valid_reg || m_ready;
    end

    // state updates and RAM writes
    always_comb begin
        used_next   = used_reg;
        active_next = active_reg;
        exp_we      = 1'b0;
        exp_waddr   = slot_reg;
        exp_wdata   = sum;
        per_we      = 1'b0;
        per_waddr   = slot_reg;
        tag_we      = 1'b0;
        idx_next    = idx_reg;

        if (ctrl.load_in) begin
            idx_next = '0;
        end else if (ctrl.inc_idx) begin
            idx_next = idx_reg + 1'b1;
        end

        if (ctrl.scan_commit) begin
            if (rd_tagrel[GB]) begin
                exp_we    = 1'b1;
                exp_waddr = idx_reg;
            end else begin
                active_next[idx_reg] = 1'b0;
            end
        end

        if (ctrl.cmd_commit && pass) begin
            case (command_reg)
                stb_pkg::CMD_CREATE: begin
                    used_next[free_idx]   = 1'b1;
                    active_next[free_idx] = 1'b0;
                    exp_we    = 1'b1;
                    exp_waddr = free_idx;
                    exp_wdata = '0;
                    per_we    = 1'b1;
                    per_waddr = free_idx;
                    tag_we    = 1'b1;
                end
                stb_pkg::CMD_START: begin
                    exp_we                = 1'b1;
                    active_next[slot_reg] = 1'b1;
                end
                stb_pkg::CMD_STOP: begin
                    active_next[slot_reg] = 1'b0;
                end
                stb_pkg::CMD_CHANGE: begin
                    per_we = 1'b1;
                    exp_we = active_reg[slot_reg];
                end
                stb_pkg::CMD_DELETE: begin
                    active_next[slot_reg] = 1'b0;
                    used_next[slot_reg]   = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // output register
    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        kind_next    = kind_reg;
        status_next  = status_reg;
        rslot_next   = rslot_reg;
        rtag_next    = rtag_reg;
        last_next    = last_reg;
        if (ctrl.scan_commit) begin
            m_valid_next = 1'b1;
            kind_next    = stb_pkg::KIND_EXPIRY;
            status_next  = 1'b0;
            rslot_next   = idx_reg;
            rtag_next    = rd_tagrel[GB-1:0];
            last_next    = 1'b0;
        end else if (ctrl.done_emit) begin
            m_valid_next = 1'b1;
            kind_next    = stb_pkg::KIND_DONE;
            status_next  = 1'b0;
            rslot_next   = '0;
            rtag_next    = '0;
            last_next    = 1'b1;
        end else if (ctrl.cmd_commit) begin
            m_valid_next = 1'b1;
            kind_next    = stb_pkg::KIND_RESP;
            status_next  = !pass;
            rslot_next   = (pass && command_reg == stb_pkg::CMD_CREATE) ? free_idx : '0;
            rtag_next    = (pass && command_reg == stb_pkg::CMD_TAG) ? rd_tagrel[GB-1:0] : '0;
            last_next    = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg    <= '0;
            active_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            used_reg    <= used_next;
            active_reg  <= active_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load_in) begin
            command_reg <= s_command;
            slot_reg    <= s_slot;
            now_reg     <= s_now;
            period_reg  <= s_period;
            reload_reg  <= s_reload;
            tag_reg     <= s_tag;
            handler_reg <= s_handler_present;
        end
        idx_reg    <= idx_next;
        kind_reg   <= kind_next;
        status_reg <= status_next;
        rslot_reg  <= rslot_next;
        rtag_reg   <= rtag_next;
        last_reg   <= last_next;
    end

    stb_ram #(.WIDTH(TB), .DEPTH(NS)) u_expiry_ram (
        .aclk  (aclk),
        .we    (exp_we),
        .waddr (exp_waddr),
        .wdata (exp_wdata),
        .raddr (raddr),
        .rdata (rd_expiry)
    );

    stb_ram #(.WIDTH(TB), .DEPTH(NS)) u_period_ram (
        .aclk  (aclk),
        .we    (per_we),
        .waddr (per_waddr),
        .wdata (period_reg),
        .raddr (raddr),
        .rdata (rd_period)
    );

    // tag with the reload flag on top
    stb_ram #(.WIDTH(GB + 1), .DEPTH(NS)) u_tag_ram (
        .aclk  (aclk),
        .we    (tag_we),
        .waddr (free_idx),
        .wdata ({reload_reg, tag_reg}),
        .raddr (raddr),
        .rdata (rd_tagrel)
    );

    assign m_valid       = m_valid_reg;
    assign m_kind        = kind_reg;
    assign m_status      = status_reg;
    assign m_result_slot = rslot_reg;
    assign m_result_tag  = rtag_reg;
    assign m_last        = last_reg;

endmodule

`default_nettype wire

### src/software_timer_bank.sv
// Pool of 16 software timer slots, one command per input beat.
// Input channel (s_*): command, slot, now, period, reload, tag, handler_present.
// Output channel (m_*): kind, status, result_slot, result_tag, last; m_last
// marks the final result beat caused by one input beat.
// A command other than tick passes through the accept, slot RAM read and
// response states, and its response beat is registered as the response
// state ends. A tick walks the slots in index order through a single read
// port of the slot RAMs: a slot that is free or stopped takes only the
// check step, a live slot that has not expired takes check and evaluate,
// and one that expires takes check, evaluate and emit and gives an event
// beat; the done beat follows the last slot. One command is in work at a
// time; s_ready is high only between commands.
// The last result sits in an output register, so a new command is accepted
// while that beat still waits for m_ready; a stalled receiver holds the beat
// and stalls the block at its next result beat, in a command or in the scan.
// Reset (aresetn low, synchronous) frees every slot and empties the output
// register; period, expiry and tag storage is not cleared, since create
// writes a slot in full before it can be read.
`timescale 1ns / 1ps
`default_nettype none

module software_timer_bank (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [2:0]                    s_command,
    input  wire logic [stb_pkg::SLOT_W-1:0]    s_slot,
    input  wire logic [stb_pkg::TICK_BITS-1:0] s_now,
    input  wire logic [stb_pkg::TICK_BITS-1:0] s_period,
    input  wire logic                          s_reload,
    input  wire logic [stb_pkg::TAG_BITS-1:0]  s_tag,
    input  wire logic                          s_handler_present,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [1:0]                         m_kind,
    output logic                               m_status,
    output logic [stb_pkg::SLOT_W-1:0]         m_result_slot,
    output logic [stb_pkg::TAG_BITS-1:0]       m_result_tag,
    output logic                               m_last
);

    stb_pkg::stb_ctrl_t ctrl;
    stb_pkg::stb_stat_t stat;

    // sequence commands and the tick scan
    stb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .ctrl    (ctrl)
    );

    // slot flags, slot RAMs, expiry compare and the output register
    stb_datapath u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .ctrl              (ctrl),
        .stat              (stat),
        .s_command         (s_command),
        .s_slot            (s_slot),
        .s_now             (s_now),
        .s_period          (s_period),
        .s_reload          (s_reload),
        .s_tag             (s_tag),
        .s_handler_present (s_handler_present),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_kind            (m_kind),
        .m_status          (m_status),
        .m_result_slot     (m_result_slot),
        .m_result_tag      (m_result_tag),
        .m_last            (m_last)
    );

endmodule

`default_nettype wire
